/* rtl/battery_days_left_forecaster_top_macros.svh */
// Assertion macros shared by the battery forecaster modules
`ifndef BATTERY_DAYS_LEFT_FORECASTER_TOP_MACROS_SVH
`define BATTERY_DAYS_LEFT_FORECASTER_TOP_MACROS_SVH

// Check a property on the rising clock, held off during reset
`define BDLF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock at every edge, reset included
`define BDLF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bdlf_pkg.sv */
// Types, constants and register codes of the battery days-left forecaster
`default_nettype none
package bdlf_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int DIV_W         = 27;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;

    localparam logic [DIV_W-1:0] DAY_MS      = 27'd86400000;
    localparam logic [DIV_W-1:0] HALF_DAY_MS = 27'd43200000;
    localparam logic [15:0]      UNKNOWN_LEVEL = 16'hffff;

    localparam logic [13:0] LEVEL_STEP_RST   = 14'd20;
    localparam logic [31:0] SETTLE_DELAY_RST = 32'd3600000;
    localparam logic [31:0] MIN_EPOCH_RST    = 32'd86400000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EPOCH    = 2'd2;

    typedef struct packed {
        logic [47:0] now_ms;
        logic [15:0] level;
        logic        on_battery;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] days_left;
        logic               days_valid;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

/* rtl/bdlf_div.sv */
// Iterative restoring divider, one quotient bit per cycle
`default_nettype none
module bdlf_div #(
    parameter int DW = 67
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DW-1:0]             dividend,
    input  wire logic [bdlf_pkg::DIV_W-1:0] divisor,
    output logic [DW-1:0]                  quotient,
    output bdlf_pkg::div_stat_t            stat
);
    import bdlf_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;

    // Shift in one dividend bit and try a subtract
    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DW-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_W])
            begin
                rem_next = diff[DIV_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIV_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

`include "battery_days_left_forecaster_top_macros.svh"

    `BDLF_ASSERT(a_start_busy, clk, rst_n, start && !busy_reg |=> busy_reg, "divider did not start")
    `BDLF_ASSERT(a_done_idle, clk, rst_n, done_reg |-> !busy_reg && $past(busy_reg), "done without run")
    `BDLF_ASSERT(a_cnt_zero, clk, rst_n, !busy_reg |-> cnt_reg == '0 || start, "count left over")

endmodule
`default_nettype wire

/* rtl/battery_days_left_forecaster_top.sv */
// Battery days-left forecaster: tracker, sequencer and shared divider
//
// in_valid/in_ready take one sample (uptime, charge level, on-battery flag);
// out_valid/out_ready give exactly one result per sample: days_left and
// days_valid. cfg_we with cfg_idx/cfg_data writes a register; the user
// must write only while the block is idle, which the block does not enforce.
// A sample that gives no forecast goes straight to the output; a plain
// forecast runs one division, the third change up to two and a full
// re-estimate up to three, one after another on the single shared divider
// of width DW = max(TIME_BITS + 18, 67), which retires one quotient bit
// per cycle.
// in_ready is high only while the sequencer is idle. A finished result sits
// in the output register; when the receiver stalls, the next sample may be
// taken and worked, and its result waits until the output register frees.
// Reset loads the register defaults, clears the tracker and empties the
// output register.
`default_nettype none
module battery_days_left_forecaster_top #(
    parameter int TIME_BITS = bdlf_pkg::TIME_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire bdlf_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output bdlf_pkg::out_item_t                 out_data,
    input  wire logic                           cfg_we,
    input  wire logic [bdlf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [bdlf_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bdlf_pkg::*;

    localparam int DW = (TIME_BITS + 18 > 67) ? TIME_BITS + 18 : 67;
    localparam int PW = TIME_BITS + 18;
    localparam logic [DW-1:0] MAG_POS_MAX = DW'(64'h7fff_ffff_ffff_ffff);
    localparam logic [DW-1:0] MAG_NEG_MAX = DW'(64'h8000_0000_0000_0000);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_EMUL   = 7'b0000100,
        S_DAYS   = 7'b0001000,
        S_START  = 7'b0010000,
        S_WAIT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic [13:0] level_step_reg, level_step_next;
    logic [31:0] settle_reg, settle_next;
    logic [31:0] min_epoch_reg, min_epoch_next;

    // Sample
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [15:0]          lvl_reg, lvl_next;
    logic                 onb_reg, onb_next;

    // Tracker
    logic [2:0]           cnt_reg, cnt_next;
    logic [15:0]          cur_lvl_reg, cur_lvl_next;
    logic [15:0]          first_lvl_reg, first_lvl_next;
    logic [TIME_BITS-1:0] first_time_reg, first_time_next;
    logic [15:0]          last_lvl_reg, last_lvl_next;
    logic [TIME_BITS-1:0] last_time_reg, last_time_next;
    logic signed [63:0]   left_reg, left_next;
    logic [TIME_BITS:0]   earliest_reg, earliest_next;

    // Work
    logic signed [TIME_BITS:0] span_reg, span_next;
    logic                      full_reg, full_next;
    logic                      est_idx_reg, est_idx_next;
    logic                      day_reg, day_next;
    logic signed [DW-1:0]      work_reg, work_next;
    logic [DIV_W-1:0]          dvs_reg, dvs_next;
    logic                      dneg_reg, dneg_next;
    logic                      qneg_reg, qneg_next;
    logic signed [15:0]        res_days_reg, res_days_next;
    logic                      res_ok_reg, res_ok_next;
    logic                      out_valid_reg, out_valid_next;
    out_item_t                 out_data_reg, out_data_next;

    // Divider
    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [DW-1:0] div_q;
    div_stat_t     div_stat;

    // Combinational helpers
    logic signed [16:0]        lvl_diff;
    logic                      is_change;
    logic [2:0]                cnt_inc;
    logic signed [TIME_BITS:0] span_now;
    logic signed [TIME_BITS:0] est_span;
    logic [15:0]               ref_lvl;
    logic signed [16:0]        drop;
    logic signed [PW-1:0]      prod;
    logic signed [63:0]        est_val;
    logic signed [64:0]        sum;
    logic signed [64:0]        sum_adj;
    logic signed [DW-1:0]      t_val;
    logic signed [15:0]        days_val;

    bdlf_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dvs_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Sequencer and tracker update
    always_comb
    begin
        state_next      = state_reg;
        level_step_next = level_step_reg;
        settle_next     = settle_reg;
        min_epoch_next  = min_epoch_reg;
        now_next        = now_reg;
        lvl_next        = lvl_reg;
        onb_next        = onb_reg;
        cnt_next        = cnt_reg;
        cur_lvl_next    = cur_lvl_reg;
        first_lvl_next  = first_lvl_reg;
        first_time_next = first_time_reg;
        last_lvl_next   = last_lvl_reg;
        last_time_next  = last_time_reg;
        left_next       = left_reg;
        earliest_next   = earliest_reg;
        span_next       = span_reg;
        full_next       = full_reg;
        est_idx_next    = est_idx_reg;
        day_next        = day_reg;
        work_next       = work_reg;
        dvs_next        = dvs_reg;
        dneg_next       = dneg_reg;
        qneg_next       = qneg_reg;
        res_days_next   = res_days_reg;
        res_ok_next     = res_ok_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        div_start       = 1'b0;
        div_dividend    = work_reg[DW-1] ? DW'(-work_reg) : DW'(work_reg);

        lvl_diff  = $signed({1'b0, cur_lvl_reg}) - $signed({1'b0, lvl_reg});
        is_change = lvl_diff > $signed({3'b000, level_step_reg});
        cnt_inc   = (cnt_reg == 3'd4) ? 3'd4 : cnt_reg + 3'd1;
        span_now  = $signed({1'b0, now_reg}) - $signed({1'b0, last_time_reg});
        est_span  = est_idx_reg ? $signed({1'b0, now_reg}) - $signed({1'b0, first_time_reg})
                                : span_reg;
        ref_lvl   = est_idx_reg ? first_lvl_reg : last_lvl_reg;
        drop      = $signed({1'b0, ref_lvl}) - $signed({1'b0, lvl_reg});
        prod      = PW'(est_span) * PW'($signed({1'b0, lvl_reg}));

        // Saturate the signed estimate to 64 bits
        if (qneg_reg)
            est_val = (div_q > MAG_NEG_MAX) ? $signed(64'h8000_0000_0000_0000)
                                             : -$signed(div_q[63:0]);
        else
            est_val = (div_q > MAG_POS_MAX) ? $signed(64'h7fff_ffff_ffff_ffff)
                                             : $signed(div_q[63:0]);
        sum     = $signed({left_reg[63], left_reg}) + $signed({est_val[63], est_val});
        sum_adj = sum + $signed({64'd0, sum[64]});

        // Days in 16 bits, saturated
        if (qneg_reg)
            days_val = (div_q > DW'(32768)) ? -16'sd32768 : -$signed(div_q[15:0]);
        else
            days_val = (div_q > DW'(32767)) ? 16'sd32767 : $signed(div_q[15:0]);

        t_val = DW'(left_reg) - DW'(span_reg) + $signed(DW'(HALF_DAY_MS));

        // Register writes
        if (cfg_we)
        begin
            case (cfg_idx)
                REG_LEVEL_STEP:   level_step_next = cfg_data[13:0];
                REG_SETTLE_DELAY: settle_next     = cfg_data;
                REG_MIN_EPOCH:    min_epoch_next  = cfg_data;
                default:          ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    now_next   = TIME_BITS'(in_data.now_ms);
                    lvl_next   = in_data.level;
                    onb_next   = in_data.on_battery;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_days_next = -16'sd1;
                res_ok_next   = 1'b0;
                full_next     = 1'b0;
                est_idx_next  = 1'b0;
                span_next     = span_now;
                state_next    = S_OUT;
                if (lvl_reg == UNKNOWN_LEVEL || !onb_reg)
                begin
                    // Clear the tracker and hold off forecasts
                    cnt_next       = 3'd0;
                    first_lvl_next = UNKNOWN_LEVEL;
                    last_lvl_next  = UNKNOWN_LEVEL;
                    cur_lvl_next   = UNKNOWN_LEVEL;
                    left_next      = -64'sd1;
                    earliest_next  = {1'b0, now_reg} + (TIME_BITS + 1)'(settle_reg);
                end
                else if ({1'b0, now_reg} >= earliest_reg)
                begin
                    if (is_change)
                    begin
                        cur_lvl_next = lvl_reg;
                        cnt_next     = cnt_inc;
                        if (cnt_inc == 3'd2)
                        begin
                            first_lvl_next  = lvl_reg;
                            first_time_next = now_reg;
                            last_lvl_next   = lvl_reg;
                            last_time_next  = now_reg;
                        end
                        else if (cnt_inc != 3'd1)
                        begin
                            if (!span_now[TIME_BITS] &&
                                span_now[TIME_BITS-1:0] >= TIME_BITS'(min_epoch_reg))
                            begin
                                full_next  = 1'b1;
                                state_next = S_EMUL;
                            end
                            else if (cnt_inc == 3'd3)
                                state_next = S_EMUL;
                            else
                                state_next = S_DAYS;
                        end
                    end
                    else if (cnt_reg >= 3'd3)
                        state_next = S_DAYS;
                end
            end
            S_EMUL:
            begin
                // Product and drop of one estimate; a zero drop ends the sample
                if (drop == 17'sd0)
                    state_next = S_OUT;
                else
                begin
                    work_next  = DW'(prod);
                    dvs_next   = DIV_W'(drop[16] ? -drop : drop);
                    dneg_next  = drop[16];
                    day_next   = 1'b0;
                    state_next = S_START;
                end
            end
            S_DAYS:
            begin
                work_next  = t_val;
                dvs_next   = DAY_MS;
                dneg_next  = 1'b0;
                day_next   = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                div_start  = 1'b1;
                qneg_next  = work_reg[DW-1] ^ dneg_reg;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (day_reg)
                    begin
                        res_days_next = days_val;
                        res_ok_next   = 1'b1;
                        state_next    = S_OUT;
                    end
                    else if (!est_idx_reg)
                    begin
                        left_next = est_val;
                        if (full_reg)
                        begin
                            last_lvl_next  = lvl_reg;
                            last_time_next = now_reg;
                            est_idx_next   = 1'b1;
                            state_next     = S_EMUL;
                        end
                        else
                            state_next = S_DAYS;
                    end
                    else
                    begin
                        // Average the two estimates, rounding toward zero
                        left_next  = sum_adj[64:1];
                        span_next  = '0;
                        state_next = S_DAYS;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next.days_left  = res_days_reg;
                    out_data_next.days_valid = res_ok_reg;
                    state_next               = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            level_step_reg <= LEVEL_STEP_RST;
            settle_reg     <= SETTLE_DELAY_RST;
            min_epoch_reg  <= MIN_EPOCH_RST;
            cnt_reg        <= 3'd0;
            cur_lvl_reg    <= UNKNOWN_LEVEL;
            first_lvl_reg  <= UNKNOWN_LEVEL;
            first_time_reg <= '0;
            last_lvl_reg   <= UNKNOWN_LEVEL;
            last_time_reg  <= '0;
            left_reg       <= -64'sd1;
            earliest_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_step_reg <= level_step_next;
            settle_reg     <= settle_next;
            min_epoch_reg  <= min_epoch_next;
            cnt_reg        <= cnt_next;
            cur_lvl_reg    <= cur_lvl_next;
            first_lvl_reg  <= first_lvl_next;
            first_time_reg <= first_time_next;
            last_lvl_reg   <= last_lvl_next;
            last_time_reg  <= last_time_next;
            left_reg       <= left_next;
            earliest_reg   <= earliest_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        lvl_reg      <= lvl_next;
        onb_reg      <= onb_next;
        span_reg     <= span_next;
        full_reg     <= full_next;
        est_idx_reg  <= est_idx_next;
        day_reg      <= day_next;
        work_reg     <= work_next;
        dvs_reg      <= dvs_next;
        dneg_reg     <= dneg_next;
        qneg_reg     <= qneg_next;
        res_days_reg <= res_days_next;
        res_ok_reg   <= res_ok_next;
        out_data_reg <= out_data_next;
    end

`include "battery_days_left_forecaster_top_macros.svh"

    `BDLF_ASSERT_ALWAYS(a_cnt_range, clk, !rst_n || cnt_reg <= 3'd4, "change count beyond four")
    `BDLF_ASSERT(a_take_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "second sample taken")
    `BDLF_ASSERT(a_div_owner, clk, rst_n, div_stat.busy |-> state_reg == S_WAIT, "divider runs unowned")
    `BDLF_ASSERT(a_fcst_count, clk, rst_n, out_valid_reg && out_data_reg.days_valid && $rose(out_valid_reg) |-> cnt_reg >= 3'd3, "forecast before third change")

endmodule
`default_nettype wire
